// ===== rtl/clnb_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the cell list neighbor builder
// no dependencies

package clnb_pkg;

    localparam int POS_BITS = 16;
    localparam int CMD_W    = 2;
    localparam int PIDX_W   = 10;
    localparam int CFG_W    = 32;
    localparam int SIDE_W   = 5;
    localparam int SIDE_MIN = 3;
    localparam int QDEPTH   = 2;

    localparam int DEF_MAX_PARTICLES      = 1024;
    localparam int DEF_CELL_CAPACITY      = 256;
    localparam int DEF_MAX_NEIGHBORS      = 64;
    localparam int DEF_MAX_CELLS_PER_SIDE = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic REG_SIDE   = 1'b0;
    localparam logic REG_CUTOFF = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY
    } clnb_op_t;

    typedef struct packed {
        clnb_op_t              op;
        logic [POS_BITS-1:0]   x_pos;
        logic [POS_BITS-1:0]   y_pos;
        logic [PIDX_W-1:0]     particle;
    } clnb_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_CELL,
        ST_LD_FILL,
        ST_Q_COORD,
        ST_Q_CELL,
        ST_Q_FILL,
        ST_Q_MEM,
        ST_Q_J,
        ST_Q_SQ,
        ST_Q_CMP,
        ST_Q_END
    } clnb_state_t;

endpackage

// ===== rtl/clnb_if.sv =====
`timescale 1ns / 1ps
// input and result channel interfaces (valid/ready)
// depends on clnb_pkg

interface clnb_in_if;
    import clnb_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [POS_BITS-1:0] x_pos;
    logic [POS_BITS-1:0] y_pos;
    logic [PIDX_W-1:0]   particle;

    modport source (output valid, cmd, x_pos, y_pos, particle, input ready);
    modport sink (input valid, cmd, x_pos, y_pos, particle, output ready);
endinterface

interface clnb_out_if;
    import clnb_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIDX_W-1:0] neighbor_index;
    logic              found;
    logic              last;
    logic              cell_overflow;
    logic              list_overflow;
    logic              bad_query;

    modport source (output valid, neighbor_index, found, last, cell_overflow,
                    list_overflow, bad_query, input ready);
    modport sink (input valid, neighbor_index, found, last, cell_overflow,
                  list_overflow, bad_query, output ready);
endinterface

// ===== rtl/cell_list_neighbor_builder_top.sv =====
`timescale 1ns / 1ps
// clear: applied as the item is taken; load: position write, then a cell step and a fill step for each of 9 cells
// query: setup (position read, cell select, fill read), then a member read and index check per
// cell entry; an entry above the queried index also gets position read, square and compare;
// a final step sends last; run length is set by the single sequential scan of one cell list
// a 2-deep item queue lets the front accept while the back works; results leave through
// an output register; reset clears control state at once, no store clearing pass
// depends on clnb_pkg, clnb_if, clnb_front, clnb_back

module cell_list_neighbor_builder_top #(
    parameter int MAX_PARTICLES      = clnb_pkg::DEF_MAX_PARTICLES,
    parameter int CELL_CAPACITY      = clnb_pkg::DEF_CELL_CAPACITY,
    parameter int MAX_NEIGHBORS      = clnb_pkg::DEF_MAX_NEIGHBORS,
    parameter int MAX_CELLS_PER_SIDE = clnb_pkg::DEF_MAX_CELLS_PER_SIDE
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic                       wr_index,
    input  logic [clnb_pkg::CFG_W-1:0] wr_data,
    clnb_in_if.sink                    in_ch,
    clnb_out_if.source                 out_ch
);
    import clnb_pkg::*;

    logic [SIDE_W-1:0] side_reg, side_next;
    logic [CFG_W-1:0]  cutoff_reg, cutoff_next;
    clnb_item_t        q_item;
    logic              q_valid;
    logic              q_pop;

    always_comb
    begin
        side_next   = side_reg;
        cutoff_next = cutoff_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SIDE:   side_next   = wr_data[SIDE_W-1:0];
                REG_CUTOFF: cutoff_next = wr_data;
                default:    side_next   = side_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg   <= SIDE_W'(4);
            cutoff_reg <= '0;
        end
        else
        begin
            side_reg   <= side_next;
            cutoff_reg <= cutoff_next;
        end
    end

    clnb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    clnb_back #(
        .MAX_PARTICLES      (MAX_PARTICLES),
        .CELL_CAPACITY      (CELL_CAPACITY),
        .MAX_NEIGHBORS      (MAX_NEIGHBORS),
        .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cells_per_side (side_reg),
        .cutoff_sq      (cutoff_reg),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .out_ch         (out_ch)
    );

endmodule

// ===== rtl/clnb_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram, one write port, one registered read port
// no dependencies

module clnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/clnb_front.sv =====
`timescale 1ns / 1ps
// front end: accepts items, decodes the command and queues them
// depends on clnb_pkg and clnb_if

module clnb_front (
    input  logic                clk,
    input  logic                rst_n,
    clnb_in_if.sink             in_ch,
    output clnb_pkg::clnb_item_t q_item,
    output logic                q_valid,
    input  logic                q_pop
);
    import clnb_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    clnb_item_t       entry_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    clnb_item_t       dec_item;
    logic             dec_keep;
    logic             push;
    logic             pop;

    // unused command code is accepted and dropped here
    always_comb
    begin
        dec_item.x_pos    = in_ch.x_pos;
        dec_item.y_pos    = in_ch.y_pos;
        dec_item.particle = in_ch.particle;
        dec_item.op       = OP_CLEAR;
        dec_keep          = 1'b1;
        unique case (in_ch.cmd)
            CMD_CLEAR: dec_item.op = OP_CLEAR;
            CMD_LOAD:  dec_item.op = OP_LOAD;
            CMD_QUERY: dec_item.op = OP_QUERY;
            default:   dec_keep = 1'b0;
        endcase
    end

    assign in_ch.ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign q_valid     = (cnt_reg != '0);
    assign q_item      = entry_reg[rd_ptr_reg];
    assign push        = in_ch.valid && in_ch.ready && dec_keep;
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

// ===== rtl/clnb_back.sv =====
`timescale 1ns / 1ps
// back end: executes clear, load and query, owns the stores and result register
// depends on clnb_pkg, clnb_if and clnb_ram

module clnb_back #(
    parameter int MAX_PARTICLES      = clnb_pkg::DEF_MAX_PARTICLES,
    parameter int CELL_CAPACITY      = clnb_pkg::DEF_CELL_CAPACITY,
    parameter int MAX_NEIGHBORS      = clnb_pkg::DEF_MAX_NEIGHBORS,
    parameter int MAX_CELLS_PER_SIDE = clnb_pkg::DEF_MAX_CELLS_PER_SIDE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [clnb_pkg::SIDE_W-1:0]   cells_per_side,
    input  logic [clnb_pkg::CFG_W-1:0]    cutoff_sq,
    input  clnb_pkg::clnb_item_t          q_item,
    input  logic                          q_valid,
    output logic                          q_pop,
    clnb_out_if.source                    out_ch
);
    import clnb_pkg::*;

    localparam int IDXW      = $clog2(MAX_PARTICLES);
    localparam int LCW       = $clog2(MAX_PARTICLES + 1);
    localparam int SW        = $clog2(MAX_CELLS_PER_SIDE + 1);
    localparam int CW        = $clog2(MAX_CELLS_PER_SIDE);
    localparam int NUM_CELLS = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
    localparam int CELLW     = $clog2(NUM_CELLS);
    localparam int KW        = $clog2(CELL_CAPACITY);
    localparam int FW        = $clog2(CELL_CAPACITY + 1);
    localparam int NCW       = $clog2(MAX_NEIGHBORS + 1);
    localparam int MEM_AW    = CELLW + KW;
    localparam int SQW       = 2 * POS_BITS;
    localparam int SUMW      = SQW + 1;

    function automatic logic [CW-1:0] coord(input logic [POS_BITS-1:0] pos,
                                            input logic [SW-1:0] mm);
        logic [POS_BITS+SW-1:0] prod;
        prod = (POS_BITS+SW)'(pos) * (POS_BITS+SW)'(mm);
        return CW'(prod >> POS_BITS);
    endfunction

    // neighbor coordinate with periodic wrap, off 0/1/2 means -1/0/+1
    function automatic logic [CW-1:0] wrap(input logic [CW-1:0] n,
                                           input logic [1:0] off,
                                           input logic [SW-1:0] mm);
        logic [CW-1:0] top;
        logic [CW-1:0] res;
        top = CW'(mm - SW'(1));
        res = n;
        unique case (off)
            2'd0:    res = (n == '0) ? top : n - 1'b1;
            2'd2:    res = (n == top) ? '0 : n + 1'b1;
            default: res = n;
        endcase
        return res;
    endfunction

    clnb_state_t state_reg, state_next;

    logic [LCW-1:0]       loaded_reg, loaded_next;
    logic                 flag_reg, flag_next;
    logic [NUM_CELLS-1:0] valid_reg, valid_next;
    logic [IDXW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]        nx_reg, nx_next, ny_reg, ny_next;
    logic [1:0]           a_reg, a_next, b_reg, b_next;
    logic [CELLW-1:0]     cell_reg, cell_next;
    logic [IDXW-1:0]      p_reg, p_next;
    logic [POS_BITS-1:0]  px_reg, px_next, py_reg, py_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        k_reg, k_next;
    logic [IDXW-1:0]      j_reg, j_next;
    logic [SQW-1:0]       sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [NCW-1:0]       cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDXW-1:0]      pend_j_reg, pend_j_next;
    logic                 lovf_reg, lovf_next;

    logic                 ov_reg, ov_next;
    logic [PIDX_W-1:0]    o_idx_reg, o_idx_next;
    logic                 o_found_reg, o_found_next;
    logic                 o_last_reg, o_last_next;
    logic                 o_covf_reg, o_covf_next;
    logic                 o_lovf_reg, o_lovf_next;
    logic                 o_bad_reg, o_bad_next;

    // memory ports
    logic                 pos_we;
    logic [IDXW-1:0]      pos_waddr, pos_raddr;
    logic [POS_BITS-1:0]  posx_rdata, posy_rdata;
    logic                 fill_we;
    logic [CELLW-1:0]     fill_waddr, fill_raddr;
    logic [FW-1:0]        fill_wdata, fill_rdata;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
    logic [IDXW-1:0]      mem_rdata;

    logic [SW-1:0]        side;
    logic                 out_free;
    logic [FW-1:0]        fill_eff;
    logic [SUMW-1:0]      sq_sum;
    logic                 hit;
    logic                 bad;
    logic [CW-1:0]        cx, cy;
    logic signed [POS_BITS-1:0] dx, dy;
    logic signed [SQW-1:0]      pdx, pdy;

    clnb_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_PARTICLES)) u_pos_x (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(q_item.x_pos),
        .raddr(pos_raddr), .rdata(posx_rdata)
    );

    clnb_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_PARTICLES)) u_pos_y (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(q_item.y_pos),
        .raddr(pos_raddr), .rdata(posy_rdata)
    );

    clnb_ram #(.WIDTH(FW), .DEPTH(NUM_CELLS)) u_fill (
        .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .raddr(fill_raddr), .rdata(fill_rdata)
    );

    clnb_ram #(.WIDTH(IDXW), .DEPTH(1 << MEM_AW)) u_members (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(idx_reg),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    always_comb
    begin
        if (int'(cells_per_side) < SIDE_MIN)
        begin
            side = SW'(SIDE_MIN);
        end
        else if (int'(cells_per_side) > MAX_CELLS_PER_SIDE)
        begin
            side = SW'(MAX_CELLS_PER_SIDE);
        end
        else
        begin
            side = SW'(cells_per_side);
        end
    end

    assign out_free = !ov_reg || out_ch.ready;
    // a cell never written since the last clear reads as empty
    assign fill_eff = valid_reg[cell_reg] ? fill_rdata : '0;
    assign sq_sum   = SUMW'(sqx_reg) + SUMW'(sqy_reg);
    assign hit      = sq_sum < SUMW'(cutoff_sq);
    assign bad      = (int'(q_item.particle) >= int'(loaded_reg));
    assign cx       = wrap(nx_reg, a_reg, side);
    assign cy       = wrap(ny_reg, b_reg, side);
    assign dx       = $signed(px_reg - posx_rdata);
    assign dy       = $signed(py_reg - posy_rdata);
    assign pdx      = SQW'(dx) * SQW'(dx);
    assign pdy      = SQW'(dy) * SQW'(dy);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        OP_LOAD:
                        begin
                            if (int'(loaded_reg) < MAX_PARTICLES)
                            begin
                                state_next = ST_LD_CELL;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!bad)
                            begin
                                state_next = ST_Q_COORD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_CELL: state_next = ST_LD_FILL;
            ST_LD_FILL:
            begin
                state_next = (a_reg == 2'd2 && b_reg == 2'd2) ? ST_IDLE : ST_LD_CELL;
            end
            ST_Q_COORD: state_next = ST_Q_CELL;
            ST_Q_CELL:  state_next = ST_Q_FILL;
            ST_Q_FILL:  state_next = ST_Q_MEM;
            ST_Q_MEM:   state_next = (k_reg == fill_reg) ? ST_Q_END : ST_Q_J;
            ST_Q_J:     state_next = (mem_rdata <= p_reg) ? ST_Q_MEM : ST_Q_SQ;
            ST_Q_SQ:    state_next = ST_Q_CMP;
            ST_Q_CMP:
            begin
                if (hit && int'(cnt_reg) < MAX_NEIGHBORS && pend_reg && !out_free)
                begin
                    state_next = ST_Q_CMP;
                end
                else
                begin
                    state_next = ST_Q_MEM;
                end
            end
            ST_Q_END:   state_next = out_free ? ST_IDLE : ST_Q_END;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        loaded_next  = loaded_reg;
        flag_next    = flag_reg;
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cell_next    = cell_reg;
        p_next       = p_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        fill_next    = fill_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        pend_j_next  = pend_j_reg;
        lovf_next    = lovf_reg;

        ov_next      = ov_reg && !out_ch.ready;
        o_idx_next   = o_idx_reg;
        o_found_next = o_found_reg;
        o_last_next  = o_last_reg;
        o_covf_next  = o_covf_reg;
        o_lovf_next  = o_lovf_reg;
        o_bad_next   = o_bad_reg;

        q_pop        = 1'b0;
        pos_we       = 1'b0;
        pos_waddr    = IDXW'(loaded_reg);
        pos_raddr    = IDXW'(q_item.particle);
        fill_we      = 1'b0;
        fill_waddr   = cell_reg;
        fill_wdata   = fill_eff + 1'b1;
        fill_raddr   = CELLW'(cx) + CELLW'(side * SW'(cy));
        mem_we       = 1'b0;
        mem_waddr    = {cell_reg, fill_eff[KW-1:0]};
        mem_raddr    = {cell_reg, k_reg[KW-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        OP_CLEAR:
                        begin
                            q_pop       = 1'b1;
                            valid_next  = '0;
                            loaded_next = '0;
                            flag_next   = 1'b0;
                        end
                        OP_LOAD:
                        begin
                            q_pop = 1'b1;
                            if (int'(loaded_reg) < MAX_PARTICLES)
                            begin
                                pos_we      = 1'b1;
                                idx_next    = IDXW'(loaded_reg);
                                loaded_next = loaded_reg + 1'b1;
                                nx_next     = coord(q_item.x_pos, side);
                                ny_next     = coord(q_item.y_pos, side);
                                a_next      = 2'd0;
                                b_next      = 2'd0;
                            end
                        end
                        OP_QUERY:
                        begin
                            p_next = IDXW'(q_item.particle);
                            if (!bad)
                            begin
                                q_pop = 1'b1;
                            end
                            else if (out_free)
                            begin
                                q_pop        = 1'b1;
                                ov_next      = 1'b1;
                                o_idx_next   = '0;
                                o_found_next = 1'b0;
                                o_last_next  = 1'b1;
                                o_covf_next  = flag_reg;
                                o_lovf_next  = 1'b0;
                                o_bad_next   = 1'b1;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_LD_CELL:
            begin
                cell_next = fill_raddr;
            end
            ST_LD_FILL:
            begin
                if (int'(fill_eff) >= CELL_CAPACITY)
                begin
                    flag_next = 1'b1;
                end
                else
                begin
                    mem_we               = 1'b1;
                    fill_we              = 1'b1;
                    valid_next[cell_reg] = 1'b1;
                end
                if (a_reg == 2'd2)
                begin
                    a_next = 2'd0;
                    b_next = b_reg + 1'b1;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            ST_Q_COORD:
            begin
                px_next = posx_rdata;
                py_next = posy_rdata;
                nx_next = coord(posx_rdata, side);
                ny_next = coord(posy_rdata, side);
            end
            ST_Q_CELL:
            begin
                fill_raddr = CELLW'(nx_reg) + CELLW'(side * SW'(ny_reg));
                cell_next  = fill_raddr;
            end
            ST_Q_FILL:
            begin
                fill_next = fill_eff;
                k_next    = '0;
                cnt_next  = '0;
                pend_next = 1'b0;
                lovf_next = 1'b0;
            end
            ST_Q_MEM:
            begin
                if (k_reg != fill_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_Q_J:
            begin
                j_next    = mem_rdata;
                pos_raddr = mem_rdata;
            end
            ST_Q_SQ:
            begin
                sqx_next = SQW'(pdx);
                sqy_next = SQW'(pdy);
            end
            ST_Q_CMP:
            begin
                // hold one match back so the final one can carry last
                if (hit)
                begin
                    if (int'(cnt_reg) < MAX_NEIGHBORS)
                    begin
                        if (!pend_reg || out_free)
                        begin
                            if (pend_reg)
                            begin
                                ov_next      = 1'b1;
                                o_idx_next   = PIDX_W'(pend_j_reg);
                                o_found_next = 1'b1;
                                o_last_next  = 1'b0;
                                o_covf_next  = flag_reg;
                                o_lovf_next  = 1'b0;
                                o_bad_next   = 1'b0;
                            end
                            pend_next   = 1'b1;
                            pend_j_next = j_reg;
                            cnt_next    = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        lovf_next = 1'b1;
                    end
                end
            end
            ST_Q_END:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_idx_next   = pend_reg ? PIDX_W'(pend_j_reg) : '0;
                    o_found_next = pend_reg;
                    o_last_next  = 1'b1;
                    o_covf_next  = flag_reg;
                    o_lovf_next  = lovf_reg;
                    o_bad_next   = 1'b0;
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            flag_reg   <= 1'b0;
            valid_reg  <= '0;
            ov_reg     <= 1'b0;
            a_reg      <= '0;
            b_reg      <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            lovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            flag_reg   <= flag_next;
            valid_reg  <= valid_next;
            ov_reg     <= ov_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            lovf_reg   <= lovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        cell_reg    <= cell_next;
        p_reg       <= p_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        fill_reg    <= fill_next;
        j_reg       <= j_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        pend_j_reg  <= pend_j_next;
        o_idx_reg   <= o_idx_next;
        o_found_reg <= o_found_next;
        o_last_reg  <= o_last_next;
        o_covf_reg  <= o_covf_next;
        o_lovf_reg  <= o_lovf_next;
        o_bad_reg   <= o_bad_next;
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.neighbor_index = o_idx_reg;
    assign out_ch.found          = o_found_reg;
    assign out_ch.last           = o_last_reg;
    assign out_ch.cell_overflow  = o_covf_reg;
    assign out_ch.list_overflow  = o_lovf_reg;
    assign out_ch.bad_query      = o_bad_reg;

endmodule
